FILE: rtl/core/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types, constants and helpers for the leapfrog particle update block.
// ----------------------------------------------------------------------------
package lpf_pkg;

    localparam int DATA_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int TS_W      = 17;
    localparam int VS_W      = 19;
    localparam int BOX_W     = 31;
    localparam int KE_W      = 63;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;

    localparam logic [TS_W-1:0]  TS_RESET  = TS_W'(328);
    localparam logic [VS_W-1:0]  VS_RESET  = VS_W'(65536);
    localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(655360);
    localparam logic [KE_W-1:0]  KE_MAX    = '1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP = 2'd0,
        CFG_VEL_SCALE = 2'd1,
        CFG_BOX_LEN   = 2'd2
    } t_cfg_idx;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [MUL_W-1:0]  t_mul_op;
    typedef logic signed [PROD_W-1:0] t_prod;

    function automatic t_word sat32(input t_wide x);
        t_wide hi;
        t_wide lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = 64'shFFFF_FFFF_8000_0000;
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[DATA_W-1:0];
    endfunction

endpackage

FILE: rtl/core/lpf_in_if.sv
// ----------------------------------------------------------------------------
// lpf_in_if
// Particle item channel: valid/ready handshake with particle payload.
// ----------------------------------------------------------------------------
interface lpf_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic               track_disp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               last;

    modport source (
        output valid, op, track_disp, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, force_x, force_y, force_z, last,
        input  ready
    );
    modport sink (
        input  valid, op, track_disp, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, force_x, force_y, force_z, last,
        output ready
    );
endinterface

FILE: rtl/core/lpf_out_if.sv
// ----------------------------------------------------------------------------
// lpf_out_if
// Result item channel: valid/ready handshake with updated particle payload.
// ----------------------------------------------------------------------------
interface lpf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] free_x;
    logic signed [31:0] free_y;
    logic signed [31:0] free_z;
    logic [62:0]        kinetic_total;
    logic               done_res;

    modport source (
        output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, free_x, free_y, free_z, kinetic_total, done_res,
        input  ready
    );
    modport sink (
        input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, free_x, free_y, free_z, kinetic_total, done_res,
        output ready
    );
endinterface

FILE: rtl/core/lpf_mul.sv
// ----------------------------------------------------------------------------
// lpf_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module lpf_mul (
    input  logic            i_clk,
    input  lpf_pkg::t_mul_op i_a,
    input  lpf_pkg::t_mul_op i_b,
    output lpf_pkg::t_prod   o_p
);
    lpf_pkg::t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

FILE: rtl/core/leapfrog_particle_update_top.sv
// ----------------------------------------------------------------------------
// leapfrog_particle_update_top
// Leapfrog particle update: one shared multiplier sequenced over three axes.
// ----------------------------------------------------------------------------
// Step item: S_VS, then per axis S_FD, S_ADD, S_ND, S_NN and S_ACC for three
//   axes, S_ACC also starting the next axis's velocity product, with four
//   products per axis on the shared multiplier; then wrap states S_W1 and S_W2, and S_FIN.
// Load item: goes from idle straight to S_FIN; items are taken only in idle.
// A stalled result holds the next item in the finish state until it drains.
// Reset (synchronous, active low) clears control, registers to defaults,
//   index and energy sum; the unwrapped position store is not cleared.
// ----------------------------------------------------------------------------
module leapfrog_particle_update_top #(
    parameter int MAX_PARTICLES = 1024,
    parameter int FRAC_BITS     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lpf_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [lpf_pkg::CFG_W-1:0]         i_cfg_data,
    lpf_in_if.sink                            i_item,
    lpf_out_if.source                         o_res
);
    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int MEM_W = 3 * lpf_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_IDLE, S_VS, S_FD, S_ADD, S_ND, S_NN, S_ACC, S_W1, S_W2, S_FIN
    } t_state;

    t_state                    r_state;
    logic [1:0]                r_axis;
    logic [lpf_pkg::TS_W-1:0]  r_ts;
    logic [lpf_pkg::VS_W-1:0]  r_vs;
    logic [lpf_pkg::BOX_W-1:0] r_box;
    logic [IDX_W-1:0]          r_idx;
    logic [lpf_pkg::KE_W-1:0]  r_energy;
    logic [63:0]               r_ke;

    logic                      r_op;
    logic                      r_track;
    logic                      r_last;
    lpf_pkg::t_word            r_p    [3];
    lpf_pkg::t_word            r_v    [3];
    lpf_pkg::t_word            r_f    [3];
    lpf_pkg::t_word            r_nv   [3];
    lpf_pkg::t_word            r_np   [3];
    lpf_pkg::t_word            r_free [3];
    lpf_pkg::t_wide            r_acc;
    lpf_pkg::t_wide            r_d;
    lpf_pkg::t_wide            r_q;
    lpf_pkg::t_wide            r_q2;
    logic                      r_w1_v;
    logic [1:0]                r_w1_ax;
    logic                      r_w2_v;
    logic [1:0]                r_w2_ax;

    logic [MEM_W-1:0]          r_mem [MAX_PARTICLES];
    logic [MEM_W-1:0]          r_mem_q;

    logic                      r_ov;
    lpf_pkg::t_word            r_o_np [3];
    lpf_pkg::t_word            r_o_nv [3];
    lpf_pkg::t_word            r_o_fr [3];
    logic [lpf_pkg::KE_W-1:0]  r_o_ke;
    logic                      r_o_done;

    logic                      w_accept;
    logic                      w_fin_go;
    logic [1:0]                w_ax_nxt;
    lpf_pkg::t_mul_op          w_mul_a;
    lpf_pkg::t_mul_op          w_mul_b;
    lpf_pkg::t_prod            w_prod;
    lpf_pkg::t_wide            w_fl;
    lpf_pkg::t_wide            w_box;
    lpf_pkg::t_word            w_store;
    logic [63:0]               w_esum;
    logic                      w_mem_we;
    logic [MEM_W-1:0]          w_mem_wd;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_fin_go     = (r_state == S_FIN) && (!r_ov || o_res.ready);
    assign w_ax_nxt     = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
    assign w_fl         = 64'(w_prod >>> FRAC_BITS);
    assign w_box        = lpf_pkg::t_wide'({33'd0, r_box});
    assign w_esum       = {1'b0, r_energy} + {1'b0, r_ke[63:1]};

    always_comb begin
        unique case (r_axis)
            2'd1:    w_store = r_mem_q[2*lpf_pkg::DATA_W-1 -: lpf_pkg::DATA_W];
            2'd2:    w_store = r_mem_q[3*lpf_pkg::DATA_W-1 -: lpf_pkg::DATA_W];
            default: w_store = r_mem_q[lpf_pkg::DATA_W-1:0];
        endcase
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_VS: begin
                w_mul_a = lpf_pkg::t_mul_op'(r_v[r_axis]);
                w_mul_b = lpf_pkg::t_mul_op'({14'd0, r_vs});
            end
            S_FD: begin
                w_mul_a = lpf_pkg::t_mul_op'(r_f[r_axis]);
                w_mul_b = lpf_pkg::t_mul_op'({16'd0, r_ts});
            end
            S_ND: begin
                w_mul_a = lpf_pkg::t_mul_op'(r_nv[r_axis]);
                w_mul_b = lpf_pkg::t_mul_op'({16'd0, r_ts});
            end
            S_NN: begin
                w_mul_a = lpf_pkg::t_mul_op'(r_nv[r_axis]);
                w_mul_b = lpf_pkg::t_mul_op'(r_nv[r_axis]);
            end
            S_ACC: begin
                w_mul_a = lpf_pkg::t_mul_op'(r_v[w_ax_nxt]);
                w_mul_b = lpf_pkg::t_mul_op'({14'd0, r_vs});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    lpf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // unwrapped position store
    assign w_mem_we = (w_accept && (i_item.op == lpf_pkg::OP_LOAD)) ||
                      (w_fin_go && (r_op == lpf_pkg::OP_STEP) && r_track);
    assign w_mem_wd = w_accept ? {i_item.pos_z, i_item.pos_y, i_item.pos_x}
                               : {r_free[2], r_free[1], r_free[0]};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= w_mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem_q <= r_mem[r_idx];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts  <= lpf_pkg::TS_RESET;
            r_vs  <= lpf_pkg::VS_RESET;
            r_box <= lpf_pkg::BOX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lpf_pkg::CFG_TIME_STEP: r_ts  <= i_cfg_data[lpf_pkg::TS_W-1:0];
                lpf_pkg::CFG_VEL_SCALE: r_vs  <= i_cfg_data[lpf_pkg::VS_W-1:0];
                lpf_pkg::CFG_BOX_LEN:   r_box <= i_cfg_data[lpf_pkg::BOX_W-1:0];
                default: ;
            endcase
        end
    end

    // wrap pipe: subtract box if above it, then add box if negative and saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1_v <= 1'b0;
            r_w2_v <= 1'b0;
        end else begin
            r_w1_v <= (r_state == S_ACC);
            r_w2_v <= r_w1_v;
        end
        if (r_state == S_ACC) begin
            r_w1_ax <= r_axis;
        end
        if (r_w1_v) begin
            r_q2    <= (r_q > w_box) ? r_q - w_box : r_q;
            r_w2_ax <= r_w1_ax;
        end
        if (r_w2_v) begin
            r_np[r_w2_ax] <= lpf_pkg::sat32((r_q2 < 0) ? r_q2 + w_box : r_q2);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= 2'd0;
            r_idx    <= '0;
            r_energy <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready && !w_fin_go) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_item.op;
                        r_track <= i_item.track_disp;
                        r_last  <= i_item.last;
                        r_p[0]  <= i_item.pos_x;
                        r_p[1]  <= i_item.pos_y;
                        r_p[2]  <= i_item.pos_z;
                        r_v[0]  <= i_item.vel_x;
                        r_v[1]  <= i_item.vel_y;
                        r_v[2]  <= i_item.vel_z;
                        r_f[0]  <= i_item.force_x;
                        r_f[1]  <= i_item.force_y;
                        r_f[2]  <= i_item.force_z;
                        r_axis  <= 2'd0;
                        r_ke    <= '0;
                        r_state <= (i_item.op == lpf_pkg::OP_STEP) ? S_VS : S_FIN;
                    end
                end
                S_VS: begin
                    r_state <= S_FD;
                end
                S_FD: begin
                    r_acc   <= w_fl;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_nv[r_axis] <= lpf_pkg::sat32(r_acc + w_fl);
                    r_state      <= S_ND;
                end
                S_ND: begin
                    r_state <= S_NN;
                end
                S_NN: begin
                    r_d     <= w_fl;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_ke           <= r_ke + w_prod[63:0];
                    r_q            <= lpf_pkg::t_wide'(r_p[r_axis]) + r_d;
                    r_free[r_axis] <= r_track ?
                        lpf_pkg::sat32(lpf_pkg::t_wide'(w_store) + r_d) : w_store;
                    if (r_axis == 2'd2) begin
                        r_state <= S_W1;
                    end else begin
                        r_axis  <= w_ax_nxt;
                        r_state <= S_FD;
                    end
                end
                S_W1: begin
                    r_energy <= w_esum[63] ? lpf_pkg::KE_MAX : w_esum[62:0];
                    r_state  <= S_W2;
                end
                S_W2: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_ov     <= 1'b1;
                        r_o_done <= r_last;
                        r_o_ke   <= r_last ? r_energy : '0;
                        for (int a = 0; a < 3; a++) begin
                            if (r_op == lpf_pkg::OP_STEP) begin
                                r_o_np[a] <= r_np[a];
                                r_o_nv[a] <= r_nv[a];
                                r_o_fr[a] <= r_free[a];
                            end else begin
                                r_o_np[a] <= r_p[a];
                                r_o_nv[a] <= r_v[a];
                                r_o_fr[a] <= r_p[a];
                            end
                        end
                        if (r_last) begin
                            r_energy <= '0;
                            r_idx    <= '0;
                        end else if (r_idx == IDX_W'(MAX_PARTICLES - 1)) begin
                            r_idx <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.new_pos_x     = r_o_np[0];
    assign o_res.new_pos_y     = r_o_np[1];
    assign o_res.new_pos_z     = r_o_np[2];
    assign o_res.new_vel_x     = r_o_nv[0];
    assign o_res.new_vel_y     = r_o_nv[1];
    assign o_res.new_vel_z     = r_o_nv[2];
    assign o_res.free_x        = r_o_fr[0];
    assign o_res.free_y        = r_o_fr[1];
    assign o_res.free_z        = r_o_fr[2];
    assign o_res.kinetic_total = r_o_ke;
    assign o_res.done_res      = r_o_done;

`ifndef NO_ASSERTIONS
    a_ke_zero_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.done_res |-> o_res.kinetic_total == '0)
        else $error("kinetic total nonzero on a non-last item");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish state");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_axis != 2'd3)
        else $error("axis counter out of range");

    a_wrap_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w1_v |=> r_w2_v && !r_w1_v)
        else $error("wrap pipe overlap");
`endif

endmodule
